// ===== rtl/gmae_pkg.sv =====
// ----------------------------------------------------------------------------
// gmae_pkg
// Shared types and constants of the session admission and eviction block.
// ----------------------------------------------------------------------------
package gmae_pkg;

	// Session table geometry
	localparam int MAX_SESSIONS = 16;
	localparam int TIME_BITS    = 48;
	localparam int IDX_W        = $clog2(MAX_SESSIONS);
	localparam int CNT_W        = $clog2(MAX_SESSIONS + 1);

	// Fixed field widths
	localparam int OP_W    = 3;
	localparam int SLOT_W  = 4;
	localparam int TYPE_W  = 2;
	localparam int BYTES_W = 48;
	localparam int THR_W   = 16;
	localparam int ACT_W   = 2;
	localparam int COUNT_W = 5;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 48;

	// Projected use is used bytes plus a budget: one carry bit more
	localparam int PROJ_W = BYTES_W + 1;

	// Shared multiply-accumulate unit: 32 x 16 partial products into a
	// signed accumulator that holds the difference of two 64-bit products
	localparam int MAC_A_W  = 32;
	localparam int MAC_B_W  = 16;
	localparam int MAC_P_W  = MAC_A_W + MAC_B_W;
	localparam int ACC_W    = 66;

	// Percent times 256 scale: 100 * 256
	localparam logic [MAC_B_W-1:0] PCT_SCALE = 16'd25600;

	typedef enum logic [OP_W-1:0] {
		OP_REGISTER   = 3'd0,
		OP_UNREGISTER = 3'd1,
		OP_TOUCH      = 3'd2,
		OP_ADMIT      = 3'd3,
		OP_ENFORCE    = 3'd4
	} op_t;

	typedef enum logic [ACT_W-1:0] {
		ACT_NONE      = 2'd0,
		ACT_REJECT    = 2'd1,
		ACT_DEGRADE   = 2'd2,
		ACT_TERMINATE = 2'd3
	} act_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_REJECT_THR    = 3'd0,
		CFG_DEGRADE_THR   = 3'd1,
		CFG_TERMINATE_THR = 3'd2,
		CFG_CT_BUDGET     = 3'd3,
		CFG_FLOW_BUDGET   = 3'd4,
		CFG_GENERIC_BUDGET = 3'd5,
		CFG_MONITOR       = 3'd6,
		CFG_EVICT_EN      = 3'd7
	} cfg_idx_t;

	// Control word for one partial product step
	typedef struct packed {
		logic valid;   // step present
		logic clear;   // first step of a compare: restart the sum
		logic neg;     // subtract this partial product
		logic hi;      // partial product weighs 2^32
	} mac_ctl_t;

endpackage

// ===== rtl/gmae_ram.sv =====
// ----------------------------------------------------------------------------
// gmae_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module gmae_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/gmae_mac.sv =====
// ----------------------------------------------------------------------------
// gmae_mac
// Shared multiply-accumulate unit: one 32x16 partial product per cycle,
// registered, then added to or subtracted from a signed accumulator.
// ge reports that the accumulated difference is not negative.
// ----------------------------------------------------------------------------
module gmae_mac (
	input  logic                      clk,
	input  logic                      arst_n,
	input  gmae_pkg::mac_ctl_t        ctl,
	input  logic [gmae_pkg::MAC_A_W-1:0] a,
	input  logic [gmae_pkg::MAC_B_W-1:0] b,
	output logic                      ge
);
	import gmae_pkg::*;

	mac_ctl_t               ctl_s1;
	logic [MAC_P_W-1:0]     prod_s1;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [ACC_W-1:0] term;

	// stage 1: partial product
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1 <= ctl;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= MAC_P_W'(a) * MAC_P_W'(b);
	end

	// weight and sign of the partial product
	always_comb begin
		term = ctl_s1.hi ? (ACC_W'(prod_s1) << MAC_A_W) : ACC_W'(prod_s1);
		if (ctl_s1.neg) begin
			term = -term;
		end
	end

	// stage 2: accumulate
	always_ff @(posedge clk) begin
		if (ctl_s1.valid) begin
			acc_q <= ctl_s1.clear ? term : acc_q + term;
		end
	end

	assign ge = !acc_q[ACC_W-1];

endmodule

// ===== rtl/gmae_lru_ctl.sv =====
// ----------------------------------------------------------------------------
// gmae_lru_ctl
// Session table (valid bits, active count, last-active RAM) with the
// least-recently-active scan. Walks the RAM one slot per cycle on request.
// ----------------------------------------------------------------------------
module gmae_lru_ctl (
	input  logic                          clk,
	input  logic                          arst_n,
	// table update, one cycle
	input  logic                          upd_en,
	input  gmae_pkg::op_t                 upd_op,
	input  logic [gmae_pkg::IDX_W-1:0]    upd_addr,
	input  logic [gmae_pkg::TIME_BITS-1:0] upd_time,
	// scan start and eviction commit
	input  logic                          scan_start,
	input  logic                          evict_commit,
	output logic                          scan_done,
	output logic                          best_found,
	output logic [gmae_pkg::IDX_W-1:0]    best_idx,
	output logic [gmae_pkg::CNT_W-1:0]    active_cnt
);
	import gmae_pkg::*;

	logic [MAX_SESSIONS-1:0] valid_q;
	logic [CNT_W-1:0]        cnt_q;
	logic                    scan_q;
	logic                    scan_end_q;
	logic [IDX_W-1:0]        scan_idx_q;
	logic                    rd_en_s1;
	logic [IDX_W-1:0]        rd_idx_s1;
	logic                    best_found_q;
	logic [IDX_W-1:0]        best_q;
	logic [TIME_BITS-1:0]    best_time_q;
	logic                    ram_we;
	logic [TIME_BITS-1:0]    ram_rdata;
	logic                    hit;
	logic                    last_idx;

	// slot types are not kept: no operation reads them back
	gmae_ram #(
		.WIDTH(TIME_BITS),
		.DEPTH(MAX_SESSIONS)
	) u_time_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(upd_addr),
		.wdata(upd_time),
		.raddr(scan_idx_q),
		.rdata(ram_rdata)
	);

	assign ram_we = upd_en && ((upd_op == OP_REGISTER) ||
		((upd_op == OP_TOUCH) && valid_q[upd_addr]));

	// strictly older wins, so ties keep the lower index
	assign hit = rd_en_s1 && valid_q[rd_idx_s1] &&
		(!best_found_q || (ram_rdata < best_time_q));
	assign last_idx = (scan_idx_q == IDX_W'(MAX_SESSIONS - 1));

	// valid bits, count and scan control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q      <= '0;
			cnt_q        <= '0;
			scan_q       <= 1'b0;
			scan_end_q   <= 1'b0;
			scan_idx_q   <= '0;
			rd_en_s1     <= 1'b0;
			best_found_q <= 1'b0;
		end else begin
			rd_en_s1   <= scan_q;
			scan_end_q <= scan_q && last_idx;
			if (hit) begin
				best_found_q <= 1'b1;
			end
			if (scan_start) begin
				scan_q       <= 1'b1;
				scan_idx_q   <= '0;
				best_found_q <= 1'b0;
			end else if (scan_q) begin
				if (last_idx) begin
					scan_q <= 1'b0;
				end else begin
					scan_idx_q <= scan_idx_q + 1'b1;
				end
			end
			if (upd_en) begin
				case (upd_op)
					OP_REGISTER: begin
						if (!valid_q[upd_addr]) begin
							cnt_q <= cnt_q + 1'b1;
						end
						valid_q[upd_addr] <= 1'b1;
					end
					OP_UNREGISTER: begin
						if (valid_q[upd_addr]) begin
							cnt_q <= cnt_q - 1'b1;
						end
						valid_q[upd_addr] <= 1'b0;
					end
					default: begin
					end
				endcase
			end
			if (evict_commit && best_found_q) begin
				valid_q[best_q] <= 1'b0;
				cnt_q           <= cnt_q - 1'b1;
			end
		end
	end

	// scan data path
	always_ff @(posedge clk) begin
		rd_idx_s1 <= scan_idx_q;
		if (hit) begin
			best_q      <= rd_idx_s1;
			best_time_q <= ram_rdata;
		end
	end

	// last read consumed in the cycle after the last index was issued
	assign scan_done  = scan_end_q;
	assign best_found = best_found_q;
	assign best_idx   = best_q;
	assign active_cnt = cnt_q;

endmodule

// ===== rtl/gpu_memory_admission_lru_evictor.sv =====
// ----------------------------------------------------------------------------
// gpu_memory_admission_lru_evictor
// Session table with memory admission check, utilization enforcement and
// least-recently-active eviction.
//
//   channel   handshake            word
//   --------  -------------------  ------------------------------------------
//   in        in_valid / in_stall  opcode, slot, type, time, bytes, info flag
//   out       out_valid/ out_stall action, admit, eviction, count, budget
//   cfg       cfg_we               cfg_index, cfg_data (no read-back)
//
// One word at a time. Table ops pass ST_EXEC and ST_RESP to the output
// register; when monitoring is live, admission runs one threshold compare
// and enforcement one to three, plus the LRU walk on terminate if eviction
// is enabled. Each compare is four partial products through the one shared
// 32x16 multiplier; the walk reads the last-active RAM one slot per cycle.
// Reset clears all slots and loads the default thresholds and budgets.
// A stalled output holds its word; the block then waits before loading the
// next one.
// ----------------------------------------------------------------------------
module gpu_memory_admission_lru_evictor (
	input  logic                              clk,
	input  logic                              arst_n,
	// config
	input  logic                              cfg_we,
	input  logic [gmae_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [gmae_pkg::CFG_DATA_W-1:0]   cfg_data,
	// input channel
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [gmae_pkg::OP_W-1:0]         opcode,
	input  logic [gmae_pkg::SLOT_W-1:0]       session_slot,
	input  logic [gmae_pkg::TYPE_W-1:0]       session_type,
	input  logic [gmae_pkg::BYTES_W-1:0]      current_time,
	input  logic [gmae_pkg::BYTES_W-1:0]      used_bytes,
	input  logic [gmae_pkg::BYTES_W-1:0]      total_bytes,
	input  logic                              info_valid,
	// output channel
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [gmae_pkg::ACT_W-1:0]        action,
	output logic                              admit,
	output logic                              evicted_valid,
	output logic [gmae_pkg::SLOT_W-1:0]       evicted_slot,
	output logic [gmae_pkg::COUNT_W-1:0]      active_count,
	output logic [gmae_pkg::BYTES_W-1:0]      budget_bytes
);
	import gmae_pkg::*;

	typedef enum logic [8:0] {
		ST_IDLE  = 9'b000000001,
		ST_EXEC  = 9'b000000010,
		ST_ISSUE = 9'b000000100,
		ST_DRAIN = 9'b000001000,
		ST_EVAL  = 9'b000010000,
		ST_SCAN  = 9'b000100000,
		ST_EVICT = 9'b001000000,
		ST_RESP  = 9'b010000000,
		ST_WAIT  = 9'b100000000
	} state_t;

	typedef enum logic [1:0] {
		SEL_REJECT    = 2'd0,
		SEL_DEGRADE   = 2'd1,
		SEL_TERMINATE = 2'd2
	} thr_sel_t;

	state_t state_q;
	thr_sel_t sel_q;
	logic [1:0] step_q;

	// configuration registers
	logic [THR_W-1:0]   reject_thr_q;
	logic [THR_W-1:0]   degrade_thr_q;
	logic [THR_W-1:0]   terminate_thr_q;
	logic [BYTES_W-1:0] ct_budget_q;
	logic [BYTES_W-1:0] flow_budget_q;
	logic [BYTES_W-1:0] generic_budget_q;
	logic               monitor_q;
	logic               evict_en_q;

	// captured word
	op_t                op_q;
	logic [SLOT_W-1:0]  slot_q;
	logic [TYPE_W-1:0]  type_q;
	logic [TIME_BITS-1:0] now_q;
	logic [PROJ_W-1:0]  proj_q;
	logic [BYTES_W-1:0] total_q;
	logic               live_q;

	// result in progress
	act_t               res_action_q;
	logic               res_admit_q;
	logic               res_ev_valid_q;
	logic [IDX_W-1:0]   res_ev_slot_q;

	// output register
	logic               out_valid_q;
	logic [ACT_W-1:0]   action_q;
	logic               admit_q;
	logic               evicted_valid_q;
	logic [SLOT_W-1:0]  evicted_slot_q;
	logic [COUNT_W-1:0] active_count_q;
	logic [BYTES_W-1:0] budget_bytes_q;

	logic               accept;
	logic               out_free;
	logic               in_rng;
	logic [IDX_W-1:0]   slot_addr;
	logic [BYTES_W-1:0] in_budget;
	logic [BYTES_W-1:0] cur_budget;
	logic [THR_W-1:0]   thr;
	mac_ctl_t           mac_ctl;
	logic [MAC_A_W-1:0] mac_a;
	logic [MAC_B_W-1:0] mac_b;
	logic               ge;
	logic               scan_start;
	logic               scan_done;
	logic               best_found;
	logic [IDX_W-1:0]   best_idx;
	logic [CNT_W-1:0]   active_cnt;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign out_free = !out_valid_q || !out_stall;
	assign in_rng   = (32'(slot_q) < MAX_SESSIONS);
	assign slot_addr = IDX_W'(slot_q);

	// type budget; types 2 and 3 use generic
	function automatic logic [BYTES_W-1:0] budget_of(
		input logic [TYPE_W-1:0]  t,
		input logic [BYTES_W-1:0] ct,
		input logic [BYTES_W-1:0] flow,
		input logic [BYTES_W-1:0] gen
	);
		logic [BYTES_W-1:0] r;
		case (t)
			2'd0:    r = ct;
			2'd1:    r = flow;
			default: r = gen;
		endcase
		return r;
	endfunction

	assign in_budget  = budget_of(session_type, ct_budget_q, flow_budget_q,
		generic_budget_q);
	assign cur_budget = budget_of(type_q, ct_budget_q, flow_budget_q,
		generic_budget_q);

	// threshold under test
	always_comb begin
		case (sel_q)
			SEL_DEGRADE:   thr = degrade_thr_q;
			SEL_TERMINATE: thr = terminate_thr_q;
			default:       thr = reject_thr_q;
		endcase
	end

	// partial products of proj*25600 - thr*total
	always_comb begin
		mac_ctl.valid = (state_q == ST_ISSUE);
		mac_ctl.clear = (step_q == 2'd0);
		mac_ctl.neg   = step_q[1];
		mac_ctl.hi    = step_q[0];
		case (step_q)
			2'd0: begin
				mac_a = proj_q[MAC_A_W-1:0];
				mac_b = PCT_SCALE;
			end
			2'd1: begin
				mac_a = MAC_A_W'(proj_q[PROJ_W-1:MAC_A_W]);
				mac_b = PCT_SCALE;
			end
			2'd2: begin
				mac_a = total_q[MAC_A_W-1:0];
				mac_b = thr;
			end
			default: begin
				mac_a = MAC_A_W'(total_q[BYTES_W-1:MAC_A_W]);
				mac_b = thr;
			end
		endcase
	end

	gmae_mac u_mac (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (mac_ctl),
		.a     (mac_a),
		.b     (mac_b),
		.ge    (ge)
	);

	assign scan_start = (state_q == ST_EVAL) && (op_q != OP_ADMIT) &&
		(sel_q == SEL_TERMINATE) && ge && evict_en_q;

	gmae_lru_ctl u_lru (
		.clk         (clk),
		.arst_n      (arst_n),
		.upd_en      ((state_q == ST_EXEC) && in_rng),
		.upd_op      (op_q),
		.upd_addr    (slot_addr),
		.upd_time    (now_q),
		.scan_start  (scan_start),
		.evict_commit(state_q == ST_EVICT),
		.scan_done   (scan_done),
		.best_found  (best_found),
		.best_idx    (best_idx),
		.active_cnt  (active_cnt)
	);

	// capture of the accepted word
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= op_t'(opcode);
			slot_q  <= session_slot;
			type_q  <= session_type;
			now_q   <= TIME_BITS'(current_time);
			proj_q  <= (op_t'(opcode) == OP_ADMIT) ?
				PROJ_W'(used_bytes) + PROJ_W'(in_budget) : PROJ_W'(used_bytes);
			total_q <= total_bytes;
			live_q  <= monitor_q && info_valid;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if ((state_q == ST_RESP) && out_free) begin
			action_q        <= res_action_q;
			admit_q         <= res_admit_q;
			evicted_valid_q <= res_ev_valid_q;
			evicted_slot_q  <= SLOT_W'(res_ev_slot_q);
			active_count_q  <= COUNT_W'(active_cnt);
			budget_bytes_q  <= cur_budget;
		end
	end

	// configuration, sequencer and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reject_thr_q     <= 16'd20480;
			degrade_thr_q    <= 16'd23040;
			terminate_thr_q  <= 16'd24320;
			ct_budget_q      <= 48'd1073741824;
			flow_budget_q    <= 48'd2147483648;
			generic_budget_q <= 48'd536870912;
			monitor_q        <= 1'b0;
			evict_en_q       <= 1'b0;
			state_q          <= ST_IDLE;
			sel_q            <= SEL_REJECT;
			step_q           <= '0;
			res_action_q     <= ACT_NONE;
			res_admit_q      <= 1'b0;
			res_ev_valid_q   <= 1'b0;
			res_ev_slot_q    <= '0;
			out_valid_q      <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx_t'(cfg_index))
					CFG_REJECT_THR:     reject_thr_q     <= cfg_data[THR_W-1:0];
					CFG_DEGRADE_THR:    degrade_thr_q    <= cfg_data[THR_W-1:0];
					CFG_TERMINATE_THR:  terminate_thr_q  <= cfg_data[THR_W-1:0];
					CFG_CT_BUDGET:      ct_budget_q      <= cfg_data;
					CFG_FLOW_BUDGET:    flow_budget_q    <= cfg_data;
					CFG_GENERIC_BUDGET: generic_budget_q <= cfg_data;
					CFG_MONITOR:        monitor_q        <= cfg_data[0];
					CFG_EVICT_EN:       evict_en_q       <= cfg_data[0];
					default: begin
					end
				endcase
			end

			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						res_action_q   <= ACT_NONE;
						res_admit_q    <= 1'b0;
						res_ev_valid_q <= 1'b0;
						res_ev_slot_q  <= '0;
						state_q        <= ST_EXEC;
					end
				end
				// table ops complete here; live checks start the compare chain
				ST_EXEC: begin
					step_q  <= '0;
					state_q <= ST_RESP;
					case (op_q)
						OP_ADMIT: begin
							if (live_q) begin
								sel_q   <= SEL_REJECT;
								state_q <= ST_ISSUE;
							end else begin
								res_admit_q <= 1'b1;
							end
						end
						OP_ENFORCE: begin
							if (live_q) begin
								sel_q   <= SEL_TERMINATE;
								state_q <= ST_ISSUE;
							end
						end
						default: begin
						end
					endcase
				end
				ST_ISSUE: begin
					step_q <= step_q + 1'b1;
					if (step_q == 2'd3) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_EVAL;
				end
				// enforce walks the thresholds from terminate down to reject
				ST_EVAL: begin
					step_q  <= '0;
					state_q <= ST_RESP;
					if (op_q == OP_ADMIT) begin
						res_admit_q <= !ge;
					end else begin
						case (sel_q)
							SEL_TERMINATE: begin
								if (ge) begin
									res_action_q <= ACT_TERMINATE;
									if (evict_en_q) begin
										state_q <= ST_SCAN;
									end
								end else begin
									sel_q   <= SEL_DEGRADE;
									state_q <= ST_ISSUE;
								end
							end
							SEL_DEGRADE: begin
								if (ge) begin
									res_action_q <= ACT_DEGRADE;
								end else begin
									sel_q   <= SEL_REJECT;
									state_q <= ST_ISSUE;
								end
							end
							default: begin
								res_action_q <= ge ? ACT_REJECT : ACT_NONE;
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (scan_done) begin
						state_q <= ST_EVICT;
					end
				end
				ST_EVICT: begin
					if (best_found) begin
						res_ev_valid_q <= 1'b1;
						res_ev_slot_q  <= best_idx;
					end
					state_q <= ST_WAIT;
				end
				// count settles after the eviction commit
				ST_WAIT: begin
					state_q <= ST_RESP;
				end
				ST_RESP: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign action        = action_q;
	assign admit         = admit_q;
	assign evicted_valid = evicted_valid_q;
	assign evicted_slot  = evicted_slot_q;
	assign active_count  = active_count_q;
	assign budget_bytes  = budget_bytes_q;

endmodule

// ===== tb/gpu_memory_admission_lru_evictor_tb.sv =====
// ----------------------------------------------------------------------------
// gpu_memory_admission_lru_evictor_tb
// Self-checking bench for the session admission and LRU eviction block.
// A behavioral copy of the session table and the limit registers predicts
// every output word. Directed words hit the utilization boundaries, zero
// memory, ties and the permissive modes. Random traffic then runs under
// several limit settings with random idling on both channels and one long
// output hold.
// ----------------------------------------------------------------------------
module gpu_memory_admission_lru_evictor_tb;

	timeunit 1ns;
	timeprecision 1ps;

	import gmae_pkg::*;

	localparam logic [BYTES_W-1:0] MAX_BYTES  = {BYTES_W{1'b1}};
	localparam logic [OP_W-1:0]    OP_NOP_LO  = OP_W'(OP_ENFORCE + 1);
	localparam logic [OP_W-1:0]    OP_NOP_HI  = {OP_W{1'b1}};
	localparam int                 LAT_TAIL   = 48;
	localparam int                 HOLD_LEN   = 400;
	localparam int                 PHASE_LEN  = 200;
	localparam longint             CYCLE_CAP  = 1000000;

	typedef struct packed {
		logic [THR_W-1:0]   reject_thr;
		logic [THR_W-1:0]   degrade_thr;
		logic [THR_W-1:0]   terminate_thr;
		logic [BYTES_W-1:0] ct_budget;
		logic [BYTES_W-1:0] flow_budget;
		logic [BYTES_W-1:0] generic_budget;
		logic               monitor_on;
		logic               evict_on;
	} limits_t;

	typedef struct packed {
		logic [OP_W-1:0]    op;
		logic [SLOT_W-1:0]  slot;
		logic [TYPE_W-1:0]  kind;
		logic [BYTES_W-1:0] stamp;
		logic [BYTES_W-1:0] used;
		logic [BYTES_W-1:0] total;
		logic               info;
	} request_t;

	typedef struct packed {
		logic [ACT_W-1:0]   action;
		logic               admit;
		logic               ev_valid;
		logic [SLOT_W-1:0]  ev_slot;
		logic [COUNT_W-1:0] count;
		logic [BYTES_W-1:0] budget;
	} outcome_t;

	localparam limits_t RESET_LIMITS = '{
		reject_thr: 16'd20480, degrade_thr: 16'd23040, terminate_thr: 16'd24320,
		ct_budget: 48'd1073741824, flow_budget: 48'd2147483648,
		generic_budget: 48'd536870912, monitor_on: 1'b0, evict_on: 1'b0};

	// DUT ports
	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [OP_W-1:0]       opcode = '0;
	logic [SLOT_W-1:0]     session_slot = '0;
	logic [TYPE_W-1:0]     session_type = '0;
	logic [BYTES_W-1:0]    current_time = '0;
	logic [BYTES_W-1:0]    used_bytes = '0;
	logic [BYTES_W-1:0]    total_bytes = '0;
	logic                  info_valid = 1'b0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [ACT_W-1:0]      action;
	logic                  admit;
	logic                  evicted_valid;
	logic [SLOT_W-1:0]     evicted_slot;
	logic [COUNT_W-1:0]    active_count;
	logic [BYTES_W-1:0]    budget_bytes;

	// Predictor state: shadow limits and session table
	limits_t               limits = RESET_LIMITS;
	bit                    slot_live [MAX_SESSIONS];
	logic [BYTES_W-1:0]    slot_stamp [MAX_SESSIONS];

	outcome_t              pending_outcomes [$];
	int unsigned           mismatch_count = 0;
	longint unsigned       cycle_count = 0;
	logic [BYTES_W-1:0]    stamp_clock = '0;
	bit                    tx_quiet = 1'b0;
	logic                  rx_hold = 1'b0;
	event                  hold_start;

	gpu_memory_admission_lru_evictor dut (.*);

	always #2 clk = ~clk;

	// Run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_CAP) begin
			$display("[gpu_memory_admission_lru_evictor] ERROR");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------
	function automatic logic [BYTES_W-1:0] budget_for(logic [TYPE_W-1:0] kind);
		if (kind == 2'd0)
			return limits.ct_budget;
		else if (kind == 2'd1)
			return limits.flow_budget;
		return limits.generic_budget;
	endfunction

	// amount/total*100 >= thr/256, by exact cross-multiplication
	function automatic bit util_reaches(logic [PROJ_W-1:0] amount, logic [THR_W-1:0] thr,
			logic [BYTES_W-1:0] total);
		logic [79:0] lhs;
		logic [79:0] rhs;
		lhs = 80'(amount) * 80'(PCT_SCALE);
		rhs = 80'(thr) * 80'(total);
		return lhs >= rhs;
	endfunction

	function automatic void predict_outcome(request_t rq);
		outcome_t         o;
		bit               live;
		int               oldest;
		logic [PROJ_W-1:0] proj;
		o = '0;
		live = limits.monitor_on && rq.info;
		case (rq.op)
			OP_REGISTER: begin
				slot_live[rq.slot] = 1'b1;
				slot_stamp[rq.slot] = rq.stamp;
			end
			OP_UNREGISTER: slot_live[rq.slot] = 1'b0;
			OP_TOUCH: begin
				if (slot_live[rq.slot])
					slot_stamp[rq.slot] = rq.stamp;
			end
			OP_ADMIT: begin
				if (!live) begin
					o.admit = 1'b1;
				end else begin
					proj = {1'b0, rq.used} + {1'b0, budget_for(rq.kind)};
					o.admit = !util_reaches(proj, limits.reject_thr, rq.total);
				end
			end
			OP_ENFORCE: begin
				if (live) begin
					if (util_reaches({1'b0, rq.used}, limits.terminate_thr, rq.total)) begin
						o.action = ACT_TERMINATE;
						if (limits.evict_on) begin
							// oldest stamp wins, lowest index on ties
							oldest = -1;
							for (int i = 0; i < MAX_SESSIONS; i++)
								if (slot_live[i] && (oldest < 0 ||
										slot_stamp[i] < slot_stamp[oldest]))
									oldest = i;
							if (oldest >= 0) begin
								slot_live[oldest] = 1'b0;
								o.ev_valid = 1'b1;
								o.ev_slot = SLOT_W'(oldest);
							end
						end
					end else if (util_reaches({1'b0, rq.used}, limits.degrade_thr, rq.total)) begin
						o.action = ACT_DEGRADE;
					end else if (util_reaches({1'b0, rq.used}, limits.reject_thr, rq.total)) begin
						o.action = ACT_REJECT;
					end
				end
			end
			default: ;
		endcase
		for (int i = 0; i < MAX_SESSIONS; i++)
			o.count += COUNT_W'(slot_live[i]);
		o.budget = budget_for(rq.kind);
		pending_outcomes.push_back(o);
	endfunction

	// ------------------------------------------------------------------
	// Checking
	// ------------------------------------------------------------------
	function automatic void flag_error(string what);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%s", what);
	endfunction

	function automatic void compare_field(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got)
			flag_error($sformatf("mismatch %s: expected %0h, got %0h", name, want, got));
	endfunction

	function automatic void check_outcome();
		outcome_t want;
		if (pending_outcomes.size() == 0) begin
			flag_error("output word with nothing pending");
		end else begin
			want = pending_outcomes.pop_front();
			compare_field("action", 64'(want.action), 64'(action));
			compare_field("admit", 64'(want.admit), 64'(admit));
			compare_field("evicted_valid", 64'(want.ev_valid), 64'(evicted_valid));
			compare_field("evicted_slot", 64'(want.ev_slot), 64'(evicted_slot));
			compare_field("active_count", 64'(want.count), 64'(active_count));
			compare_field("budget_bytes", 64'(want.budget), 64'(budget_bytes));
		end
	endfunction

	// Output side: random stall per word, quiet stretches, long hold on request
	initial begin : result_sink
		int unsigned stall_left;
		bit          rx_quiet;
		stall_left = 0;
		rx_quiet = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				check_outcome();
				if ($urandom_range(0, 39) == 0)
					rx_quiet = !rx_quiet;
				stall_left = rx_quiet ? 0 : $urandom_range(0, 14);
			end
			if (rx_hold || stall_left != 0) begin
				out_stall <= 1'b1;
				if (stall_left != 0)
					stall_left--;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Long output hold, counted here
	initial begin : hold_timer
		forever begin
			@(hold_start);
			rx_hold <= 1'b1;
			repeat (HOLD_LEN) @(posedge clk);
			rx_hold <= 1'b0;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	function automatic logic [BYTES_W-1:0] rand48();
		logic [63:0] v;
		v = {$urandom(), $urandom()};
		return v[BYTES_W-1:0];
	endfunction

	function automatic request_t make_request(logic [OP_W-1:0] op, logic [SLOT_W-1:0] slot,
			logic [TYPE_W-1:0] kind, logic [BYTES_W-1:0] stamp, logic [BYTES_W-1:0] used,
			logic [BYTES_W-1:0] total, logic info);
		request_t rq;
		rq.op = op;
		rq.slot = slot;
		rq.kind = kind;
		rq.stamp = stamp;
		rq.used = used;
		rq.total = total;
		rq.info = info;
		return rq;
	endfunction

	// Mostly table upkeep and checks with used bytes close to a threshold
	function automatic request_t random_request();
		request_t         rq;
		int unsigned      pick;
		logic [THR_W-1:0] thr;
		logic [79:0]      cut;
		int               delta;
		pick = $urandom_range(0, 99);
		if (pick < 30)
			rq.op = OP_REGISTER;
		else if (pick < 42)
			rq.op = OP_UNREGISTER;
		else if (pick < 57)
			rq.op = OP_TOUCH;
		else if (pick < 75)
			rq.op = OP_ADMIT;
		else if (pick < 97)
			rq.op = OP_ENFORCE;
		else
			rq.op = OP_W'($urandom_range(OP_NOP_LO, OP_NOP_HI));
		rq.slot = SLOT_W'($urandom_range(0, MAX_SESSIONS - 1));
		rq.kind = TYPE_W'($urandom_range(0, 3));
		// mostly monotonic time with frequent repeats, sometimes anything
		stamp_clock = stamp_clock + BYTES_W'($urandom_range(0, 2));
		rq.stamp = ($urandom_range(0, 15) == 0) ? rand48() : stamp_clock;
		rq.info = ($urandom_range(0, 9) != 0);
		rq.total = ($urandom_range(0, 24) == 0) ? '0 : rand48() >> $urandom_range(0, 40);
		if ($urandom_range(0, 3) == 0) begin
			rq.used = rand48();
		end else begin
			case ($urandom_range(0, 2))
				0: thr = limits.reject_thr;
				1: thr = limits.degrade_thr;
				default: thr = limits.terminate_thr;
			endcase
			cut = 80'(thr) * 80'(rq.total);
			cut = cut / 80'(PCT_SCALE);
			delta = int'($urandom_range(0, 4)) - 2;
			rq.used = cut[BYTES_W-1:0] + BYTES_W'(delta);
			if (rq.op == OP_ADMIT)
				rq.used = rq.used - budget_for(rq.kind);
		end
		return rq;
	endfunction

	// Offer one word; valid stays up after acceptance unless the next gap lowers it
	task automatic send_word(request_t rq);
		int unsigned gap;
		gap = tx_quiet ? 0 : $urandom_range(0, 14);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= rq.op;
		session_slot <= rq.slot;
		session_type <= rq.kind;
		current_time <= rq.stamp;
		used_bytes <= rq.used;
		total_bytes <= rq.total;
		info_valid <= rq.info;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predict_outcome(rq);
	endtask

	// Stop offering and wait for every pending word plus the block's latency
	task automatic wait_all_results();
		in_valid <= 1'b0;
		while (pending_outcomes.size() != 0)
			@(posedge clk);
		repeat (LAT_TAIL) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
	endtask

	// All eight registers, only with the block idle
	task automatic apply_limits(limits_t s);
		wait_all_results();
		write_reg(CFG_REJECT_THR, CFG_DATA_W'(s.reject_thr));
		write_reg(CFG_DEGRADE_THR, CFG_DATA_W'(s.degrade_thr));
		write_reg(CFG_TERMINATE_THR, CFG_DATA_W'(s.terminate_thr));
		write_reg(CFG_CT_BUDGET, s.ct_budget);
		write_reg(CFG_FLOW_BUDGET, s.flow_budget);
		write_reg(CFG_GENERIC_BUDGET, s.generic_budget);
		write_reg(CFG_MONITOR, CFG_DATA_W'(s.monitor_on));
		write_reg(CFG_EVICT_EN, CFG_DATA_W'(s.evict_on));
		cfg_we <= 1'b0;
		limits = s;
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Reset limits: monitor off, so checks pass and enforce is quiet
	task automatic test_permissive_defaults();
		send_word(make_request(OP_ADMIT, 4'd0, 2'd0, '0, MAX_BYTES, MAX_BYTES, 1'b1));
		send_word(make_request(OP_ENFORCE, 4'd1, 2'd1, '0, MAX_BYTES, '0, 1'b1));
		send_word(make_request(OP_NOP_LO, 4'd2, 2'd2, '0, '0, '0, 1'b0));
		send_word(make_request(OP_NOP_HI, 4'd3, 2'd3, MAX_BYTES, MAX_BYTES, MAX_BYTES, 1'b1));
	endtask

	// Register, overwrite, unregister and touch of empty and live slots
	task automatic test_table_ops();
		send_word(make_request(OP_REGISTER, 4'd0, 2'd0, 48'd5, '0, '0, 1'b1));
		send_word(make_request(OP_REGISTER, 4'd15, 2'd3, MAX_BYTES, '0, '0, 1'b0));
		send_word(make_request(OP_REGISTER, 4'd0, 2'd1, 48'd7, '0, '0, 1'b1));
		send_word(make_request(OP_UNREGISTER, 4'd7, 2'd2, '0, '0, '0, 1'b1));
		send_word(make_request(OP_TOUCH, 4'd7, 2'd0, 48'd1, '0, '0, 1'b1));
		send_word(make_request(OP_TOUCH, 4'd15, 2'd1, 48'd2, '0, '0, 1'b1));
		send_word(make_request(OP_REGISTER, 4'd3, 2'd2, 48'd2, '0, '0, 1'b1));
	endtask

	// Exact threshold boundaries, zero memory, ties, failed query, empty table
	task automatic test_utilization_edges();
		limits_t s;
		s = RESET_LIMITS;
		s.monitor_on = 1'b1;
		s.evict_on = 1'b1;
		apply_limits(s);
		// total 25600: used at the terminate threshold, then one below each threshold
		send_word(make_request(OP_ENFORCE, 4'd0, 2'd0, '0, 48'd24320, 48'd25600, 1'b1));
		send_word(make_request(OP_ENFORCE, 4'd0, 2'd1, '0, 48'd24319, 48'd25600, 1'b1));
		send_word(make_request(OP_ENFORCE, 4'd0, 2'd2, '0, 48'd23039, 48'd25600, 1'b1));
		send_word(make_request(OP_ENFORCE, 4'd0, 2'd3, '0, 48'd20479, 48'd25600, 1'b1));
		send_word(make_request(OP_ENFORCE, 4'd0, 2'd0, '0, MAX_BYTES, '0, 1'b0));
		send_word(make_request(OP_ADMIT, 4'd0, 2'd0, '0, '0, MAX_BYTES, 1'b1));
		send_word(make_request(OP_ADMIT, 4'd0, 2'd1, '0, MAX_BYTES, MAX_BYTES, 1'b1));
		send_word(make_request(OP_ADMIT, 4'd0, 2'd2, '0, '0, '0, 1'b1));
		send_word(make_request(OP_ADMIT, 4'd0, 2'd3, '0, MAX_BYTES, '0, 1'b0));
		// zero total: terminate until the table is empty
		repeat (3)
			send_word(make_request(OP_ENFORCE, 4'd0, 2'd0, '0, '0, '0, 1'b1));
	endtask

	// Terminate with eviction off leaves the table alone
	task automatic test_evict_disabled();
		limits_t s;
		s = RESET_LIMITS;
		s.monitor_on = 1'b1;
		apply_limits(s);
		send_word(make_request(OP_REGISTER, 4'd5, 2'd1, 48'd9, '0, '0, 1'b1));
		send_word(make_request(OP_ENFORCE, 4'd5, 2'd0, '0, MAX_BYTES, MAX_BYTES, 1'b1));
	endtask

	// Random traffic under several limit settings, extremes among them
	task automatic test_random_traffic();
		limits_t s;
		for (int phase = 0; phase < 6; phase++) begin
			s = RESET_LIMITS;
			s.monitor_on = 1'b1;
			s.evict_on = 1'b1;
			case (phase)
				1: begin
					s.reject_thr = '0;
					s.degrade_thr = '0;
					s.terminate_thr = '0;
					s.ct_budget = '0;
					s.flow_budget = '0;
					s.generic_budget = '0;
				end
				2: begin
					s.reject_thr = '1;
					s.degrade_thr = '1;
					s.terminate_thr = '1;
					s.ct_budget = MAX_BYTES;
					s.flow_budget = MAX_BYTES;
					s.generic_budget = MAX_BYTES;
				end
				3: begin
					s.reject_thr = THR_W'($urandom());
					s.degrade_thr = THR_W'($urandom());
					s.terminate_thr = THR_W'($urandom());
					s.ct_budget = rand48() >> $urandom_range(0, 20);
					s.flow_budget = rand48() >> $urandom_range(0, 20);
					s.generic_budget = rand48() >> $urandom_range(0, 20);
					s.evict_on = 1'($urandom_range(0, 1));
				end
				4: s.monitor_on = 1'b0;
				5: s.evict_on = 1'b0;
				default: ;
			endcase
			apply_limits(s);
			repeat (PHASE_LEN)
				send_word(random_request());
		end
	endtask

	// Output held for a long stretch while words keep coming, then a full pause
	task automatic test_backpressure();
		limits_t s;
		s = RESET_LIMITS;
		s.monitor_on = 1'b1;
		s.evict_on = 1'b1;
		apply_limits(s);
		-> hold_start;
		tx_quiet = 1'b1;
		repeat (40)
			send_word(random_request());
		tx_quiet = 1'b0;
		wait_all_results();
		repeat (60)
			send_word(random_request());
	endtask

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------
	initial begin
		for (int i = 0; i < MAX_SESSIONS; i++) begin
			slot_live[i] = 1'b0;
			slot_stamp[i] = '0;
		end
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_permissive_defaults();
		test_table_ops();
		test_utilization_edges();
		test_evict_disabled();
		test_random_traffic();
		test_backpressure();

		wait_all_results();
		if (pending_outcomes.size() != 0)
			flag_error("output words missing at end of run");
		if (mismatch_count == 0)
			$display("[gpu_memory_admission_lru_evictor] OK");
		else
			$display("[gpu_memory_admission_lru_evictor] ERROR");
		$finish;
	end

endmodule
